FILE: rtl/qidt_pkg.sv
// Shared constants, types and a helper function of the query ID translation table.
package qidt_pkg;

	localparam int SLOTS_DEF = 1024;

	localparam logic [1:0] REQ_QUERY = 2'd0;
	localparam logic [1:0] REQ_RESP  = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;
	localparam logic [1:0] REQ_NONE  = 2'd3;

	localparam logic [2:0] STS_FWD       = 3'd0;
	localparam logic [2:0] STS_FWD_STALE = 3'd1;
	localparam logic [2:0] STS_RELAY     = 3'd2;
	localparam logic [2:0] STS_RANGE     = 3'd3;
	localparam logic [2:0] STS_DUP       = 3'd4;
	localparam logic [2:0] STS_TICK      = 3'd5;

	localparam logic [3:0] RCODE_SERVFAIL = 4'd2;
	localparam logic [1:0] TIMEOUT_RST    = 2'd2;
	localparam logic [1:0] AGE_MAX        = 2'd3;

	typedef struct packed {
		logic load;
		logic exec;
		logic clr;
		logic walk_start;
		logic walk;
		logic tick_out;
	} qidt_cmd_t;

	typedef struct packed {
		logic       clr_done;
		logic       walk_done;
		logic       out_free;
		logic [1:0] req_type;
	} qidt_sts_t;

	function automatic logic [2:0] bucket_of(input logic [31:0] lat);
		logic [2:0] b;
		if (lat < 32'd1000) b = 3'd0;
		else if (lat < 32'd10000) b = 3'd1;
		else if (lat < 32'd50000) b = 3'd2;
		else if (lat < 32'd100000) b = 3'd3;
		else if (lat < 32'd1000000) b = 3'd4;
		else b = 3'd5;
		return b;
	endfunction

endpackage

FILE: rtl/qidt_ctrl.sv
// Controller state machine: clearing pass, item sequencing and the tick walk.
module qidt_ctrl import qidt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  qidt_sts_t sts,
	output qidt_cmd_t cmd
);

	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_EXEC, S_TICK, S_TICK_OUT} state_t;

	state_t state_q;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			S_CLEAR: cmd.clr = 1'b1;
			S_IDLE: begin
				cmd.load = in_valid;
				cmd.walk_start = in_valid && (sts.req_type == REQ_TICK);
			end
			S_EXEC: cmd.exec = sts.out_free;
			S_TICK: cmd.walk = 1'b1;
			S_TICK_OUT: cmd.tick_out = sts.out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			case (state_q)
				S_CLEAR: if (sts.clr_done) state_q <= S_IDLE;
				S_IDLE: begin
					if (in_valid) begin
						case (sts.req_type)
							REQ_QUERY, REQ_RESP: state_q <= S_EXEC;
							REQ_TICK: state_q <= S_TICK;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_EXEC: if (sts.out_free) state_q <= S_IDLE;
				S_TICK: if (sts.walk_done) state_q <= S_TICK_OUT;
				S_TICK_OUT: if (sts.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/qidt_dp.sv
// Datapath: slot memories, counters, running average and the result register.
module qidt_dp import qidt_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  qidt_cmd_t   cmd,
	output qidt_sts_t   sts,
	input  logic        cfg_valid,
	input  logic [1:0]  cfg_data,
	input  logic [1:0]  req_type,
	input  logic [15:0] client_id,
	input  logic [15:0] reply_id,
	input  logic [15:0] client_tag,
	input  logic [15:0] delay_ms,
	input  logic [31:0] now_usec,
	input  logic [3:0]  reply_rcode,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] out_id,
	output logic [15:0] out_tag,
	output logic [15:0] out_delay_ms,
	output logic [31:0] latency_usec,
	output logic [2:0]  latency_bucket,
	output logic        servfail,
	output logic [10:0] outstanding_count,
	output logic [10:0] timeouts,
	output logic [31:0] avg_latency_usec
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [IW:0] LAST_IDX = (IW + 1)'(SLOTS - 1);
	localparam logic [IW:0] END_IDX = (IW + 1)'(SLOTS);
	localparam logic [16:0] SLOTS17 = 17'(SLOTS);
	localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);
	localparam int DW = 80;

	logic [2:0]    ba_mem [SLOTS];
	logic [DW-1:0] sd_mem [SLOTS];
	logic [2:0]    ba_rd_q;
	logic [DW-1:0] sd_rd_q;

	logic [1:0]    timeout_q;
	logic [IW-1:0] next_slot_q;
	logic [CW-1:0] busy_cnt_q;
	logic [CW-1:0] freed_q;
	logic [39:0]   avg_q;
	logic [IW:0]   idx_q;
	logic          v_s1;
	logic [IW-1:0] addr_s1;

	logic [1:0]    type_q;
	logic [IW-1:0] addr_q;
	logic          range_q;
	logic [15:0]   cid_q;
	logic [15:0]   tag_q;
	logic [15:0]   dly_q;
	logic [31:0]   now_q;
	logic [3:0]    rcode_q;

	logic          out_valid_q;
	logic [2:0]    status_q;
	logic [15:0]   out_id_q;
	logic [15:0]   out_tag_q;
	logic [15:0]   out_delay_q;
	logic [31:0]   lat_q;
	logic [2:0]    bucket_q;
	logic          servfail_q;
	logic [10:0]   outstanding_q;
	logic [10:0]   timeouts_q;
	logic [31:0]   avg_out_q;

	logic [IW-1:0] rd_addr;
	logic [IW-1:0] in_addr;
	logic          ba_we;
	logic [IW-1:0] ba_waddr;
	logic [2:0]    ba_wdata;
	logic          walk_rd;
	logic          busy_rd;
	logic [1:0]    age_rd;
	logic          timed_out;
	logic [31:0]   lat;
	logic [39:0]   avg_next;
	logic          relay;

	assign in_addr = (req_type == REQ_QUERY) ? next_slot_q : reply_id[IW-1:0];
	assign walk_rd = cmd.walk && (idx_q != END_IDX);
	assign rd_addr = cmd.load ? in_addr : idx_q[IW-1:0];
	assign busy_rd = ba_rd_q[2];
	assign age_rd = ba_rd_q[1:0];
	assign timed_out = busy_rd && (age_rd > timeout_q);
	assign lat = now_q - sd_rd_q[31:0];
	assign avg_next = avg_q - {7'd0, avg_q[39:7]} + {8'd0, lat};
	assign relay = (type_q == REQ_RESP) && range_q && busy_rd;

	assign sts.clr_done = (idx_q == LAST_IDX);
	assign sts.walk_done = (idx_q == END_IDX) && !v_s1;
	assign sts.out_free = !out_valid_q || !out_stall;
	assign sts.req_type = req_type;

	always_comb begin
		ba_we = 1'b0;
		ba_waddr = addr_q;
		ba_wdata = ba_rd_q;
		if (cmd.clr) begin
			ba_we = 1'b1;
			ba_waddr = idx_q[IW-1:0];
			ba_wdata = 3'd0;
		end else if (v_s1) begin
			ba_we = 1'b1;
			ba_waddr = addr_s1;
			if (timed_out) ba_wdata = 3'd0;
			else if (busy_rd && age_rd != AGE_MAX) ba_wdata = {1'b1, age_rd + 2'd1};
			else ba_wdata = ba_rd_q;
		end else if (cmd.exec && type_q == REQ_QUERY) begin
			ba_we = 1'b1;
			ba_wdata = {1'b1, 2'd0};
		end else if (cmd.exec && relay) begin
			ba_we = 1'b1;
			ba_wdata = {1'b0, age_rd};
		end
	end

	always_ff @(posedge clk) begin
		if (ba_we) ba_mem[ba_waddr] <= ba_wdata;
		if (cmd.load || walk_rd) ba_rd_q <= ba_mem[rd_addr];
		if (cmd.exec && type_q == REQ_QUERY) sd_mem[addr_q] <= {cid_q, tag_q, dly_q, now_q};
		if (cmd.load) sd_rd_q <= sd_mem[in_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q <= in_addr;
			range_q <= ({1'b0, reply_id} < SLOTS17);
			cid_q <= client_id;
			tag_q <= client_tag;
			dly_q <= delay_ms;
			now_q <= now_usec;
			rcode_q <= reply_rcode;
		end
		if (walk_rd) addr_s1 <= idx_q[IW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			type_q <= REQ_NONE;
			next_slot_q <= '0;
			busy_cnt_q <= '0;
			freed_q <= '0;
			avg_q <= '0;
			idx_q <= '0;
			v_s1 <= 1'b0;
		end else begin
			if (cfg_valid) timeout_q <= cfg_data;
			if (cmd.load) type_q <= req_type;
			if (cmd.clr) idx_q <= idx_q + 1'b1;
			if (cmd.walk_start) begin
				idx_q <= '0;
				freed_q <= '0;
				v_s1 <= 1'b0;
			end else if (cmd.walk) begin
				v_s1 <= walk_rd;
				if (walk_rd) idx_q <= idx_q + 1'b1;
			end
			if (v_s1 && timed_out) begin
				freed_q <= freed_q + 1'b1;
				if (busy_cnt_q != '0) busy_cnt_q <= busy_cnt_q - 1'b1;
			end
			if (cmd.exec && type_q == REQ_QUERY) begin
				next_slot_q <= (addr_q == LAST_SLOT) ? '0 : addr_q + 1'b1;
				if (!busy_rd) busy_cnt_q <= busy_cnt_q + 1'b1;
			end
			if (cmd.exec && relay) begin
				avg_q <= avg_next;
				if (busy_cnt_q != '0) busy_cnt_q <= busy_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec || cmd.tick_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec || cmd.tick_out) begin
			status_q <= STS_TICK;
			out_id_q <= '0;
			out_tag_q <= '0;
			out_delay_q <= '0;
			lat_q <= '0;
			bucket_q <= '0;
			servfail_q <= 1'b0;
			timeouts_q <= '0;
			outstanding_q <= 11'(busy_cnt_q);
			avg_out_q <= avg_q[38:7];
			if (cmd.tick_out) begin
				timeouts_q <= 11'(freed_q);
			end else if (type_q == REQ_QUERY) begin
				status_q <= busy_rd ? STS_FWD_STALE : STS_FWD;
				out_id_q <= 16'(addr_q);
				outstanding_q <= busy_rd ? 11'(busy_cnt_q) : 11'(busy_cnt_q + 1'b1);
			end else if (!range_q) begin
				status_q <= STS_RANGE;
			end else if (!busy_rd) begin
				status_q <= STS_DUP;
			end else begin
				status_q <= STS_RELAY;
				out_id_q <= sd_rd_q[79:64];
				out_tag_q <= sd_rd_q[63:48];
				out_delay_q <= sd_rd_q[47:32];
				lat_q <= lat;
				bucket_q <= bucket_of(lat);
				servfail_q <= (rcode_q == RCODE_SERVFAIL);
				outstanding_q <= (busy_cnt_q != '0) ? 11'(busy_cnt_q - 1'b1) : 11'd0;
				avg_out_q <= avg_next[38:7];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign out_id = out_id_q;
	assign out_tag = out_tag_q;
	assign out_delay_ms = out_delay_q;
	assign latency_usec = lat_q;
	assign latency_bucket = bucket_q;
	assign servfail = servfail_q;
	assign outstanding_count = outstanding_q;
	assign timeouts = timeouts_q;
	assign avg_latency_usec = avg_out_q;

endmodule

FILE: rtl/query_id_translation_table_unit.sv
// Top level of the query ID translation table: controller plus datapath.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   req_type, client_id, reply_id, client_tag, ...
//   out      output     out_valid/out_stall status, out_id, out_tag, ... avg_latency_usec
//   cfg      input      cfg_valid/cfg_ready cfg_data (timeout_ticks)
//
// A query or response reads the slot memory in S_IDLE and updates it in S_EXEC.
// A tick walks the busy and age memory one slot per cycle, then reports in S_TICK_OUT.
// After reset a clearing pass zeroes the busy and age memory; no item is accepted
// during it. A stalled result holds the final cycle of the next item.
module query_id_translation_table_unit import qidt_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [15:0] client_id,
	input  logic [15:0] reply_id,
	input  logic [15:0] client_tag,
	input  logic [15:0] delay_ms,
	input  logic [31:0] now_usec,
	input  logic [3:0]  reply_rcode,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] out_id,
	output logic [15:0] out_tag,
	output logic [15:0] out_delay_ms,
	output logic [31:0] latency_usec,
	output logic [2:0]  latency_bucket,
	output logic        servfail,
	output logic [10:0] outstanding_count,
	output logic [10:0] timeouts,
	output logic [31:0] avg_latency_usec,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data
);

	qidt_cmd_t cmd;
	qidt_sts_t sts;

	assign cfg_ready = 1'b1;

	qidt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	qidt_dp #(.SLOTS(SLOTS)) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.cfg_valid         (cfg_valid),
		.cfg_data          (cfg_data),
		.req_type          (req_type),
		.client_id         (client_id),
		.reply_id          (reply_id),
		.client_tag        (client_tag),
		.delay_ms          (delay_ms),
		.now_usec          (now_usec),
		.reply_rcode       (reply_rcode),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.status            (status),
		.out_id            (out_id),
		.out_tag           (out_tag),
		.out_delay_ms      (out_delay_ms),
		.latency_usec      (latency_usec),
		.latency_bucket    (latency_bucket),
		.servfail          (servfail),
		.outstanding_count (outstanding_count),
		.timeouts          (timeouts),
		.avg_latency_usec  (avg_latency_usec)
	);

endmodule

FILE: tb/query_id_translation_table_unit_tb.sv
// Self-checking testbench of the query ID translation table with a built-in prediction of results.
module query_id_translation_table_unit_tb;
	import qidt_pkg::*;

	localparam int NSLOT = SLOTS_DEF;
	localparam int SETTLE = NSLOT + 100;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic [1:0]  kind;
		logic [15:0] cid;
		logic [15:0] rid;
		logic [15:0] tag;
		logic [15:0] dly;
		logic [31:0] now;
		logic [3:0]  rcode;
	} req_t;

	typedef struct {
		logic [2:0]  status;
		logic [15:0] id;
		logic [15:0] tag;
		logic [15:0] dly;
		logic [31:0] lat;
		logic [2:0]  bucket;
		logic        sf;
		logic [10:0] busy;
		logic [10:0] freed;
		logic [31:0] avg;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] req_type = '0;
	logic [15:0] client_id = '0;
	logic [15:0] reply_id = '0;
	logic [15:0] client_tag = '0;
	logic [15:0] delay_ms = '0;
	logic [31:0] now_usec = '0;
	logic [3:0] reply_rcode = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] status;
	logic [15:0] out_id, out_tag, out_delay_ms;
	logic [31:0] latency_usec, avg_latency_usec;
	logic [2:0] latency_bucket;
	logic servfail;
	logic [10:0] outstanding_count, timeouts;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_data = '0;

	query_id_translation_table_unit uut (.*);

	initial forever #5 clk = ~clk;

	// Predicted state of the table.
	logic        tbl_busy [NSLOT];
	logic [1:0]  tbl_age [NSLOT];
	logic [15:0] tbl_cid [NSLOT];
	logic [15:0] tbl_tag [NSLOT];
	logic [15:0] tbl_dly [NSLOT];
	logic [31:0] tbl_sent [NSLOT];
	logic [9:0]  slot_ptr = '0;
	logic [10:0] busy_total = '0;
	logic [39:0] avg_scaled = '0;
	logic [1:0]  timeout_ticks = TIMEOUT_RST;

	req_t pending[$];
	answer_t answers[$];
	req_t cur;
	int errors = 0;
	int idle_pct = 34;
	int quiet = 0;
	logic [9:0] gen_slot = '0;
	logic [31:0] gen_now = '0;

	initial for (int i = 0; i < NSLOT; i++) begin
		tbl_busy[i] = 1'b0;
		tbl_age[i] = '0;
	end

	function automatic logic [2:0] lat_class(input logic [31:0] lat);
		if (lat < 1000) return 3'd0;
		if (lat < 10000) return 3'd1;
		if (lat < 50000) return 3'd2;
		if (lat < 100000) return 3'd3;
		if (lat < 1000000) return 3'd4;
		return 3'd5;
	endfunction

	task automatic translate(input req_t r);
		answer_t a;
		int s;
		a = '{default: '0};
		if (r.kind == REQ_NONE) return;
		if (r.kind == REQ_QUERY) begin
			s = int'(slot_ptr);
			slot_ptr = slot_ptr + 1'b1;
			if (tbl_busy[s]) a.status = STS_FWD_STALE;
			else begin
				a.status = STS_FWD;
				busy_total++;
			end
			tbl_busy[s] = 1'b1;
			tbl_age[s] = '0;
			tbl_cid[s] = r.cid;
			tbl_tag[s] = r.tag;
			tbl_dly[s] = r.dly;
			tbl_sent[s] = r.now;
			a.id = 16'(s);
		end else if (r.kind == REQ_RESP) begin
			if (r.rid >= NSLOT) a.status = STS_RANGE;
			else if (!tbl_busy[r.rid]) a.status = STS_DUP;
			else begin
				s = int'(r.rid);
				a.lat = r.now - tbl_sent[s];
				tbl_busy[s] = 1'b0;
				if (busy_total > 0) busy_total--;
				avg_scaled = avg_scaled - (avg_scaled >> 7) + {8'd0, a.lat};
				a.status = STS_RELAY;
				a.id = tbl_cid[s];
				a.tag = tbl_tag[s];
				a.dly = tbl_dly[s];
				a.bucket = lat_class(a.lat);
				a.sf = (r.rcode == RCODE_SERVFAIL);
			end
		end else begin
			for (int i = 0; i < NSLOT; i++) begin
				if (!tbl_busy[i]) continue;
				if (tbl_age[i] > timeout_ticks) begin
					tbl_age[i] = '0;
					tbl_busy[i] = 1'b0;
					if (busy_total > 0) busy_total--;
					a.freed++;
				end else if (tbl_age[i] < AGE_MAX) tbl_age[i]++;
			end
			a.status = STS_TICK;
		end
		a.busy = busy_total;
		a.avg = avg_scaled[38:7];
		answers.insert(answers.size(), a);
	endtask

	always @(posedge clk) begin
		if (!arst_n) in_valid <= 1'b0;
		else if (!in_valid || !in_stall) begin
			if (in_valid) translate(cur);
			if (pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
				cur = pending.pop_front();
				in_valid <= 1'b1;
				req_type <= cur.kind;
				client_id <= cur.cid;
				reply_id <= cur.rid;
				client_tag <= cur.tag;
				delay_ms <= cur.dly;
				now_usec <= cur.now;
				reply_rcode <= cur.rcode;
			end else in_valid <= 1'b0;
		end
	end

	task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch in %s: got %0d, expected %0d", field, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		answer_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (answers.size() == 0) begin
					report("status of an unexpected result", {29'd0, status}, 32'd0);
				end else begin
					e = answers.pop_front();
					if (status !== e.status) report("status", status, e.status);
					if (out_id !== e.id) report("out_id", out_id, e.id);
					if (out_tag !== e.tag) report("out_tag", out_tag, e.tag);
					if (out_delay_ms !== e.dly) report("out_delay_ms", out_delay_ms, e.dly);
					if (latency_usec !== e.lat) report("latency_usec", latency_usec, e.lat);
					if (latency_bucket !== e.bucket)
						report("latency_bucket", latency_bucket, e.bucket);
					if (servfail !== e.sf) report("servfail", servfail, e.sf);
					if (outstanding_count !== e.busy)
						report("outstanding_count", outstanding_count, e.busy);
					if (timeouts !== e.freed) report("timeouts", timeouts, e.freed);
					if (avg_latency_usec !== e.avg)
						report("avg_latency_usec", avg_latency_usec, e.avg);
				end
			end
			out_stall <= ($urandom_range(99) < idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic add(input logic [1:0] k, input logic [15:0] cid, input logic [15:0] rid,
			input logic [3:0] rc);
		req_t r;
		r.kind = k;
		r.cid = cid;
		r.rid = rid;
		r.tag = 16'($urandom);
		r.dly = 16'($urandom);
		r.now = gen_now;
		r.rcode = rc;
		if (k == REQ_QUERY) gen_slot++;
		pending.insert(pending.size(), r);
	endtask

	task automatic advance_time();
		case ($urandom_range(7))
			0: gen_now += $urandom_range(999);
			1: gen_now += $urandom_range(9999);
			2: gen_now += $urandom_range(60000);
			3: gen_now += $urandom_range(120000);
			4: gen_now += $urandom_range(1200000);
			5: gen_now = $urandom;
			default: gen_now += $urandom_range(50);
		endcase
	endtask

	task automatic random_items(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			advance_time();
			r = $urandom_range(99);
			if (r < 45) add(REQ_QUERY, 16'($urandom), 16'($urandom), 4'($urandom));
			else if (r < 85) begin
				r = $urandom_range(99);
				if (r < 70)
					add(REQ_RESP, 0, {6'd0, 10'(gen_slot - 1 - $urandom_range(15))},
						4'($urandom));
				else if (r < 85)
					add(REQ_RESP, 0, 16'($urandom_range(NSLOT - 1)), 4'($urandom));
				else add(REQ_RESP, 0, 16'($urandom_range(65535, NSLOT)), 4'($urandom));
			end else if (r < 95) add(REQ_TICK, 16'($urandom), 16'($urandom), 4'($urandom));
			else add(REQ_NONE, 16'($urandom), 16'($urandom), 4'($urandom));
		end
	endtask

	task automatic drain();
		while (pending.size() > 0 || in_valid || answers.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		timeout_ticks = v;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		gen_now = 32'd100;
		add(REQ_QUERY, 16'h0000, 16'h0000, 4'd0);
		add(REQ_QUERY, 16'hFFFF, 16'hFFFF, 4'd15);
		add(REQ_QUERY, 16'h1234, 16'h0, 4'd0);
		gen_now = 32'd1099;
		add(REQ_RESP, 0, 16'd0, RCODE_SERVFAIL);
		add(REQ_RESP, 0, 16'd0, 4'd2);
		gen_now = 32'd50;
		add(REQ_RESP, 16'hFFFF, 16'd1, 4'd15);
		add(REQ_RESP, 0, 16'd1024, 4'd0);
		add(REQ_RESP, 0, 16'hFFFF, 4'd0);
		add(REQ_RESP, 0, 16'd1023, 4'd0);
		add(REQ_NONE, 16'hFFFF, 16'hFFFF, 4'hF);
		repeat (4) add(REQ_TICK, 0, 0, 0);
		add(REQ_RESP, 0, 16'd2, 4'd0);
		add(REQ_QUERY, 16'hAAAA, 0, 0);
		gen_now = 32'd99_999_999;
		add(REQ_RESP, 0, {6'd0, 10'(gen_slot - 1)}, 4'd1);
		drain();

		write_timeout(2'd0);
		random_items(100);
		drain();
		write_timeout(2'd3);
		idle_pct = 0;
		random_items(100);
		drain();
		idle_pct = 34;
		write_timeout(2'd1);
		for (int i = 0; i < 150; i++) begin
			gen_now += $urandom_range(3000);
			add(REQ_QUERY, 16'($urandom), 0, 0);
		end
		random_items(40);
		drain();
		write_timeout(2'd2);
		random_items(100);
		drain();

		if (errors == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

endmodule
